>>> rtl/wes_pkg.sv
// Shared types, codes and helpers of the weekly event schedule table.
package wes_pkg;

	// Default number of table slots
	localparam int TABLE_DEPTH_DEF = 64;

	// Result queue between the scan and the response channel
	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
	localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

	// Request opcodes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ON     = 3'd1;
	localparam logic [2:0] OP_OFF    = 3'd2;
	localparam logic [2:0] OP_RAND   = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	// Day codes
	localparam logic [3:0] DAY_SUN     = 4'd0;
	localparam logic [3:0] DAY_SAT     = 4'd6;
	localparam logic [3:0] DAY_EVERY   = 4'd7;
	localparam logic [3:0] DAY_WEEKDAY = 4'd8;
	localparam logic [3:0] DAY_WEEKEND = 4'd9;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_ON   = 3'd0,
		KIND_OFF  = 3'd1,
		KIND_OK   = 3'd2,
		KIND_FULL = 3'd3,
		KIND_NONE = 3'd4
	} kind_t;

	// One stored event, 32 bits
	typedef struct packed {
		logic signed [6:0] offset;
		logic              rnd;
		logic              action;
		logic [10:0]       minute;
		logic [3:0]        day;
		logic [7:0]        light_id;
	} rec_t;

	// One result on its way to the response channel
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  light_id;
		logic        last;
	} res_t;

	// Does an entry's day rule cover the current day?
	function automatic logic day_match(logic [3:0] d, logic [3:0] td);
		logic wkend;
		logic hit;
		wkend = (td == DAY_SUN) || (td == DAY_SAT);
		if (d == DAY_EVERY) begin
			hit = 1'b1;
		end else if (td > DAY_SAT) begin
			hit = 1'b0;
		end else if (d == td) begin
			hit = 1'b1;
		end else if (d == DAY_WEEKEND) begin
			hit = wkend;
		end else if (d == DAY_WEEKDAY) begin
			hit = !wkend;
		end else begin
			hit = 1'b0;
		end
		return hit;
	endfunction

endpackage

>>> rtl/wes_if.sv
// Request and response channel interfaces of the weekly event schedule table.
interface wes_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic [7:0]        light_id;
	logic [3:0]        day_code;
	logic [10:0]       minute;
	logic signed [6:0] random_offset;

	modport source (output valid, opcode, light_id, day_code, minute, random_offset,
		input ready);
	modport sink (input valid, opcode, light_id, day_code, minute, random_offset,
		output ready);
endinterface

interface wes_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_light_id;
	logic       last;

	modport source (output valid, kind, out_light_id, last, input ready);
	modport sink (input valid, kind, out_light_id, last, output ready);
endinterface

>>> rtl/weekly_event_schedule_table_unit.sv
// Weekly event schedule table: top level with the slot scan sequencer.
//
// Every request (schedule on/off, randomize, remove, minute tick or an unknown
// opcode) walks the whole table, one slot per cycle, through the single read
// port of the record memory; each record is checked and written back in the
// cycle after its read. While a tick fires many events and the response side
// stalls, the scan pauses on the four-entry result queue. A new request is
// taken as soon as the previous one has queued its final result. Slot valid
// bits are cleared at reset, so no clearing pass is needed. Schedule fills the
// lowest free slot; a tick returns one response per fired slot in slot order,
// or one "nothing fired" response, with last set on the final one.
module weekly_event_schedule_table_unit
	import wes_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wes_req_if.sink   req,
	wes_rsp_if.source rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  slot_vld_q [TABLE_DEPTH];
	logic                  placed_q;
	logic                  pend_fired_q;
	kind_t                 pend_kind_q;
	logic [7:0]            pend_id_q;

	// Latched request
	logic [2:0]            op_q;
	logic [7:0]            id_q;
	logic [3:0]            day_q;
	logic [10:0]           min_q;
	logic signed [6:0]     roff_q;

	rec_t                  rec_s1;
	rec_t                  mem_wdata;
	logic                  mem_we;
	logic                  issue;
	logic                  scan_end;
	logic                  cur_vld;
	logic                  key_hit;
	logic signed [12:0]    due_min;
	logic                  fire;
	logic                  set_vld;
	logic                  clr_vld;
	logic                  fin_push;
	logic                  push;
	res_t                  push_res;
	logic                  q_full;
	logic [RES_CNT_W-1:0]  q_level;

	assign req.ready = (state_q == ST_IDLE);

	// Issue a read only when the result queue can absorb what is in flight
	assign scan_end = (rd_idx_q == CNT_W'(TABLE_DEPTH));
	assign issue    = (state_q == ST_SCAN) && !scan_end &&
		(({1'b0, q_level} + (RES_CNT_W + 1)'(rd_vld_s1)) < (RES_CNT_W + 1)'(RES_FIFO_DEPTH));

	wes_rec_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_s1),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rec_s1)
	);

	// Check the slot read last cycle and work out the write-back
	always_comb begin
		cur_vld   = rd_vld_s1 && slot_vld_q[idx_s1];
		key_hit   = cur_vld && (rec_s1.minute == min_q) && (rec_s1.day == day_q) &&
			(rec_s1.light_id == id_q);
		due_min   = $signed({2'b00, rec_s1.minute}) + 13'(rec_s1.offset);
		fire      = 1'b0;
		set_vld   = 1'b0;
		clr_vld   = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = rec_s1;
		case (op_q)
			OP_TICK: begin
				if (cur_vld && day_match(rec_s1.day, day_q) &&
					(due_min == $signed({2'b00, min_q}))) begin
					fire             = 1'b1;
					mem_we           = 1'b1;
					mem_wdata.offset = rec_s1.rnd ? roff_q : 7'sd0;
				end
			end
			OP_ON, OP_OFF: begin
				if (rd_vld_s1 && !slot_vld_q[idx_s1] && !placed_q) begin
					set_vld            = 1'b1;
					mem_we             = 1'b1;
					mem_wdata.offset   = 7'sd0;
					mem_wdata.rnd      = 1'b0;
					mem_wdata.action   = (op_q == OP_ON);
					mem_wdata.minute   = min_q;
					mem_wdata.day      = day_q;
					mem_wdata.light_id = id_q;
				end
			end
			OP_RAND: begin
				if (key_hit) begin
					mem_we           = 1'b1;
					mem_wdata.rnd    = 1'b1;
					mem_wdata.offset = roff_q;
				end
			end
			OP_REMOVE: begin
				clr_vld = key_hit;
			end
			default: begin
			end
		endcase
	end

	// Results: an earlier firing leaves when a later one appears; the held one
	// leaves with last set once the scan is over
	assign fin_push = (state_q == ST_FIN) && !rd_vld_s1 && !q_full;
	always_comb begin
		push     = fin_push || (fire && pend_fired_q);
		push_res = '{kind: pend_kind_q, light_id: pend_id_q, last: fin_push};
	end

	wes_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.full     (q_full),
		.level    (q_level),
		.rsp      (rsp)
	);

	// Sequencer, slot valid bits and held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			placed_q     <= 1'b0;
			pend_fired_q <= 1'b0;
			pend_kind_q  <= KIND_OK;
			pend_id_q    <= '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_vld_q[i] <= 1'b0;
			end
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q      <= ST_SCAN;
						rd_idx_q     <= '0;
						placed_q     <= 1'b0;
						pend_fired_q <= 1'b0;
						pend_id_q    <= '0;
						case (req.opcode)
							OP_TICK:       pend_kind_q <= KIND_NONE;
							OP_ON, OP_OFF: pend_kind_q <= KIND_FULL;
							default:       pend_kind_q <= KIND_OK;
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				pend_fired_q <= 1'b1;
				pend_kind_q  <= rec_s1.action ? KIND_ON : KIND_OFF;
				pend_id_q    <= rec_s1.light_id;
			end
			if (set_vld) begin
				placed_q            <= 1'b1;
				pend_kind_q         <= KIND_OK;
				slot_vld_q[idx_s1]  <= 1'b1;
			end
			if (clr_vld) begin
				slot_vld_q[idx_s1] <= 1'b0;
			end
		end
	end

	// Request fields and scan index pipeline
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.opcode;
			id_q   <= req.light_id;
			day_q  <= req.day_code;
			min_q  <= req.minute;
			roff_q <= req.random_offset;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
	end

endmodule

>>> rtl/wes_rec_mem.sv
// Event record memory: one write port, one registered read port.
module wes_rec_mem
	import wes_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/wes_res_fifo.sv
// Small result queue that drives the response channel.
module wes_res_fifo
	import wes_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  res_t                 push_res,
	output logic                 full,
	output logic [RES_CNT_W-1:0] level,
	wes_rsp_if.source            rsp
);

	res_t                 buf_q [RES_FIFO_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;
	logic                 do_push;

	assign full    = (cnt_q == RES_CNT_W'(RES_FIFO_DEPTH));
	assign level   = cnt_q;
	assign pop     = rsp.valid && rsp.ready;
	assign do_push = push && !full;

	assign rsp.valid        = (cnt_q != '0);
	assign rsp.kind         = buf_q[rd_ptr_q].kind;
	assign rsp.out_light_id = buf_q[rd_ptr_q].light_id;
	assign rsp.last         = buf_q[rd_ptr_q].last;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == RES_PTR_W'(RES_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == RES_PTR_W'(RES_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + RES_CNT_W'(do_push) - RES_CNT_W'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_res;
		end
	end

endmodule

>>> rtl/wes_chk.sv
// Port-level checker of the weekly event schedule table and its bind.
module wes_chk
	import wes_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_kind,
	input logic [7:0] rsp_light_id,
	input logic       rsp_last
);

	// One request at a time: the port closes right after taking one
	a_req_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request port stayed open after a request was taken");

	// Only switching results carry a light
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind != KIND_ON) && (rsp_kind != KIND_OFF) |-> rsp_light_id == 8'd0)
		else $error("non-switching result carries a light id");

	// Status results are always the only result of their request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_kind == KIND_OK) || (rsp_kind == KIND_FULL) ||
		(rsp_kind == KIND_NONE)) |-> rsp_last)
		else $error("status result without last");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
		$stable(rsp_light_id) && $stable(rsp_last))
		else $error("stalled result changed");

endmodule

bind weekly_event_schedule_table_unit wes_chk u_wes_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_kind     (rsp.kind),
	.rsp_light_id (rsp.out_light_id),
	.rsp_last     (rsp.last)
);
